/* hdl/bco_pkg.sv */
// Shared types, constants and helpers for the binary close/open 3x3 filter.
// No dependencies; bco_pix_if, bco_stage and the top level take names from here by scope.
`default_nettype none

package bco_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int GRAY_W      = 8;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic [GRAY_W-1:0] THRESHOLD_RST = 8'd220;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam logic OP_PIXEL = 1'b0;

    // one tick travelling down the stage chain
    typedef struct packed {
        logic tv;     // tick present
        logic has;    // tick carries a pixel
        logic pixel;
        logic last;
    } tok_t;

    function automatic logic [1:0] next_slot(input logic [1:0] s);
        logic [1:0] r;
        case (s)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // reorder a slot-indexed column into {below, center, above}
    function automatic logic [2:0] rows_of(input logic [2:0] d, input logic [1:0] s);
        logic [2:0] r;
        case (s)
            2'd0:    r = {d[1], d[0], d[2]};
            2'd1:    r = {d[2], d[1], d[0]};
            2'd2:    r = {d[0], d[2], d[1]};
            default: r = d;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bco_pix_if.sv */
// Input channel: valid/ready handshake carrying op and gray.
// Depends on bco_pkg.
`default_nettype none

interface bco_pix_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [bco_pkg::GRAY_W-1:0] gray;

    modport source (output valid, output op, output gray, input ready);
    modport sink   (input valid, input op, input gray, output ready);
endinterface

`default_nettype wire

/* hdl/bco_res_if.sv */
// Output channel: valid/ready handshake carrying result_pixel and frame_last.
// No dependencies.
`default_nettype none

interface bco_res_if;
    logic valid;
    logic ready;
    logic result_pixel;
    logic frame_last;

    modport source (output valid, output result_pixel, output frame_last, input ready);
    modport sink   (input valid, input result_pixel, input frame_last, output ready);
endinterface

`default_nettype wire

/* hdl/bco_stage.sv */
// One 3x3 binary dilate/erode stage: a three-line store memory, read/write
// pointers, backlog count and sliding window. Depends on bco_pkg.
`default_nettype none

module bco_stage #(
    parameter int MAX_WIDTH  = bco_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bco_pkg::MAX_HEIGHT_DEF,
    parameter bit DILATE     = 1'b1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 clr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       w,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]      h,
    input  bco_pkg::tok_t                        tin,
    output bco_pkg::tok_t                        tout
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int EW = WW + 1;
    localparam int BW = $clog2(MAX_WIDTH+3);

    // line store: one bit per line slot at each column
    logic [2:0] mem [MAX_WIDTH];

    logic [CW-1:0] wr_col_reg;
    logic [1:0]    wr_slot_reg;
    logic [CW-1:0] rd_col_reg;
    logic [RW-1:0] rd_row_reg;
    logic [1:0]    rd_slot_reg;
    logic [BW-1:0] backlog_reg;

    logic          tv1_reg, emit1_reg;
    logic          last1_reg, top_ok1_reg, bot_ok1_reg, left_ok1_reg, right_ok1_reg;
    logic [1:0]    slot1_reg, wslot1_reg;
    logic          fwa1_reg, fwb1_reg, wbit1_reg;
    logic [2:0]    rda_reg, rdb_reg;
    logic [2:0]    left_col_reg;
    bco_pkg::tok_t tout_reg;

    logic          take, wr_en, emit;
    logic [EW-1:0] w_ext, c_ext, bl_inc, rem;
    logic          last_row, pre_row, last_col, wr_last_col;
    logic [CW-1:0] ra, rb;
    logic [2:0]    ca, cb, mid_col, right_col, rmask, lmask, xmask;
    logic          acc;

    assign take        = tin.tv & adv;
    assign wr_en       = take & tin.has;
    assign w_ext       = EW'(w);
    assign c_ext       = EW'(rd_col_reg);
    assign bl_inc      = EW'(backlog_reg) + EW'(wr_en);
    assign last_row    = HW'(rd_row_reg) == (h - HW'(1));
    assign pre_row     = HW'(rd_row_reg) == (h - HW'(2));
    assign last_col    = WW'(rd_col_reg) == (w - WW'(1));
    assign wr_last_col = WW'(wr_col_reg) == (w - WW'(1));

    // pixels left in the frame from the read position, only near the end
    always_comb begin
        if (last_row) begin
            rem = w_ext - c_ext;
        end
        else begin
            rem = (w_ext << 1) - c_ext;
        end
    end

    assign emit = take && ((bl_inc >= w_ext + EW'(2)) ||
                           ((last_row || pre_row) && (bl_inc >= rem)));

    assign ra = rd_col_reg;
    assign rb = last_col ? rd_col_reg : rd_col_reg + CW'(1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_col_reg  <= '0;
            wr_slot_reg <= '0;
            rd_col_reg  <= '0;
            rd_row_reg  <= '0;
            rd_slot_reg <= '0;
            backlog_reg <= '0;
        end
        else if (clr) begin
            wr_col_reg  <= '0;
            wr_slot_reg <= '0;
            rd_col_reg  <= '0;
            rd_row_reg  <= '0;
            rd_slot_reg <= '0;
            backlog_reg <= '0;
        end
        else if (take) begin
            if (wr_en) begin
                if (wr_last_col) begin
                    wr_col_reg  <= '0;
                    wr_slot_reg <= bco_pkg::next_slot(wr_slot_reg);
                end
                else begin
                    wr_col_reg <= wr_col_reg + CW'(1);
                end
            end
            if (emit) begin
                if (last_col) begin
                    rd_col_reg  <= '0;
                    rd_slot_reg <= bco_pkg::next_slot(rd_slot_reg);
                    rd_row_reg  <= last_row ? '0 : rd_row_reg + RW'(1);
                end
                else begin
                    rd_col_reg <= rd_col_reg + CW'(1);
                end
            end
            backlog_reg <= BW'(bl_inc - EW'(emit));
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en && !clr) begin
            mem[wr_col_reg][wr_slot_reg] <= tin.pixel;
        end
        if (adv) begin
            rda_reg <= mem[ra];
            rdb_reg <= mem[rb];
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            last1_reg     <= last_row && last_col;
            top_ok1_reg   <= rd_row_reg != '0;
            bot_ok1_reg   <= !last_row;
            left_ok1_reg  <= rd_col_reg != '0;
            right_ok1_reg <= !last_col;
            slot1_reg     <= rd_slot_reg;
            wslot1_reg    <= wr_slot_reg;
            wbit1_reg     <= tin.pixel;
            fwa1_reg      <= wr_en && (wr_col_reg == ra);
            fwb1_reg      <= wr_en && (wr_col_reg == rb);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tv1_reg   <= 1'b0;
            emit1_reg <= 1'b0;
        end
        else if (clr) begin
            tv1_reg   <= 1'b0;
            emit1_reg <= 1'b0;
        end
        else if (adv) begin
            tv1_reg   <= take;
            emit1_reg <= emit;
        end
    end

    // a write in the read cycle is not yet in the read data
    always_comb begin
        ca = rda_reg;
        cb = rdb_reg;
        if (fwa1_reg) begin
            ca[wslot1_reg] = wbit1_reg;
        end
        if (fwb1_reg) begin
            cb[wslot1_reg] = wbit1_reg;
        end
    end

    assign mid_col   = bco_pkg::rows_of(ca, slot1_reg);
    assign right_col = bco_pkg::rows_of(cb, slot1_reg);
    assign rmask     = {bot_ok1_reg, 1'b1, top_ok1_reg};
    assign lmask     = rmask & {3{left_ok1_reg}};
    assign xmask     = rmask & {3{right_ok1_reg}};

    assign acc = DILATE ?
        |((left_col_reg & lmask) | (mid_col & rmask) | (right_col & xmask)) :
        &((left_col_reg | ~lmask) & (mid_col | ~rmask) & (right_col | ~xmask));

    always_ff @(posedge clk) begin
        if (adv && tv1_reg && emit1_reg) begin
            left_col_reg <= mid_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tout_reg <= '0;
        end
        else if (clr) begin
            tout_reg <= '0;
        end
        else if (adv) begin
            tout_reg.tv    <= tv1_reg;
            tout_reg.has   <= tv1_reg & emit1_reg;
            tout_reg.pixel <= acc;
            tout_reg.last  <= last1_reg;
        end
    end

    assign tout = tout_reg;

`ifndef SYNTHESIS
    a_backlog_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EW'(backlog_reg) <= w_ext + EW'(1))
        else $error("backlog above line width plus one");

    a_cols_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(rd_col_reg) < w) && (WW'(wr_col_reg) < w))
        else $error("column pointer outside frame");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && !clr) |=> $stable(tout_reg))
        else $error("stage output moved during stall");

    a_has_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        tout_reg.has |-> tout_reg.tv)
        else $error("result without tick");
`endif

endmodule

`default_nettype wire

/* hdl/binary_close_open_3x3.sv */
// Top level: threshold, config registers, four cascaded 3x3 stages
// (dilate, erode, erode, dilate) and output register.
// Depends on bco_pkg, bco_pix_if, bco_res_if, bco_stage.
//
//   channel   dir  handshake          payload
//   pix       in   pix.valid/ready    op, gray
//   res       out  res.valid/ready    result_pixel, frame_last
//   cfg       in   cfg_wr_en          cfg_index, cfg_data
//
// One item per cycle sustained while res keeps taking results; each stage reads
// its line store, then forms the window, both registered, and a result trails
// the tick that produces it by the line lag of frame_width+1 items per stage.
// Reset clears pointers, counters, tick flags and config registers; the line stores need no clearing.
// The pipeline halts only when stage 3 hands a result to an output register
// still holding one that res has not taken.
`default_nettype none

module binary_close_open_3x3 #(
    parameter int MAX_WIDTH  = bco_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bco_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    bco_pix_if.sink                             pix,
    bco_res_if.source                           res,
    input  logic                                cfg_wr_en,
    input  logic [bco_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bco_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int W_RST = (bco_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ?
                           MAX_WIDTH : bco_pkg::FRAME_WIDTH_RST;
    localparam int H_RST = (bco_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ?
                           MAX_HEIGHT : bco_pkg::FRAME_HEIGHT_RST;

    logic [bco_pkg::GRAY_W-1:0] thr_reg;
    logic [WW-1:0]              w_reg;
    logic [HW-1:0]              h_reg;
    logic [WW-1:0]              w_clamped;
    logic [HW-1:0]              h_clamped;
    logic                       res_valid_reg, res_pixel_reg, res_last_reg;
    logic                       adv, clr;
    bco_pkg::tok_t              tok [5];

    always_comb begin
        if (32'(cfg_data) < 3) begin
            w_clamped = WW'(3);
        end
        else if (32'(cfg_data) > MAX_WIDTH) begin
            w_clamped = WW'(MAX_WIDTH);
        end
        else begin
            w_clamped = WW'(cfg_data);
        end
        if (32'(cfg_data) < 3) begin
            h_clamped = HW'(3);
        end
        else if (32'(cfg_data) > MAX_HEIGHT) begin
            h_clamped = HW'(MAX_HEIGHT);
        end
        else begin
            h_clamped = HW'(cfg_data);
        end
    end

    assign clr = cfg_wr_en && ((cfg_index == bco_pkg::CFG_FRAME_WIDTH) ||
                               (cfg_index == bco_pkg::CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            thr_reg <= bco_pkg::THRESHOLD_RST;
            w_reg   <= WW'(W_RST);
            h_reg   <= HW'(H_RST);
        end
        else if (cfg_wr_en) begin
            unique case (cfg_index)
                bco_pkg::CFG_THRESHOLD:    thr_reg <= cfg_data[bco_pkg::GRAY_W-1:0];
                bco_pkg::CFG_FRAME_WIDTH:  w_reg   <= w_clamped;
                bco_pkg::CFG_FRAME_HEIGHT: h_reg   <= h_clamped;
                default: ;
            endcase
        end
    end

    assign adv       = !(tok[4].has && res_valid_reg && !res.ready);
    assign pix.ready = adv;

    assign tok[0].tv    = pix.valid & adv;
    assign tok[0].has   = pix.op == bco_pkg::OP_PIXEL;
    assign tok[0].pixel = pix.gray < thr_reg;
    assign tok[0].last  = 1'b0;

    for (genvar i = 0; i < 4; i++) begin : g_stage
        bco_stage #(
            .MAX_WIDTH  (MAX_WIDTH),
            .MAX_HEIGHT (MAX_HEIGHT),
            .DILATE     ((i == 0) || (i == 3))
        ) u_stage (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .clr   (clr),
            .w     (w_reg),
            .h     (h_reg),
            .tin   (tok[i]),
            .tout  (tok[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end
        else if (adv && tok[4].has) begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (adv && tok[4].has) begin
            res_pixel_reg <= tok[4].pixel;
            res_last_reg  <= tok[4].last;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.result_pixel = res_pixel_reg;
    assign res.frame_last   = res_last_reg;

endmodule

`default_nettype wire
